>>> hw/rtl/rwcp_pkg.sv
// rwcp_pkg: types, character codes and hex decode for the register write command parser
// no dependencies

package rwcp_pkg;

    localparam int CHAR_W = 8;
    localparam int REG_W  = 4;
    localparam int NIB_W  = 4;
    localparam int VAL_W  = 8;

    localparam logic [CHAR_W-1:0] CH_C_UPPER = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LOWER = 8'h63;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_A_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UPPER = 8'h46;
    localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LOWER = 8'h66;

    typedef enum logic [5:0] {
        PS_IDLE   = 6'b000001,
        PS_GOT_C  = 6'b000010,
        PS_GOT_R  = 6'b000100,
        PS_GOT_EQ = 6'b001000,
        PS_HI     = 6'b010000,
        PS_LO     = 6'b100000
    } t_parse_state;

    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] ch);
        t_hex              res;
        logic [CHAR_W-1:0] diff;
        res  = '0;
        diff = '0;
        if (ch inside {[CH_ZERO:CH_NINE]}) begin
            diff    = ch - CH_ZERO;
            res.ok  = 1'b1;
            res.nib = diff[NIB_W-1:0];
        end else if (ch inside {[CH_A_UPPER:CH_F_UPPER]}) begin
            diff    = ch - CH_A_UPPER + 8'd10;
            res.ok  = 1'b1;
            res.nib = diff[NIB_W-1:0];
        end else if (ch inside {[CH_A_LOWER:CH_F_LOWER]}) begin
            diff    = ch - CH_A_LOWER + 8'd10;
            res.ok  = 1'b1;
            res.nib = diff[NIB_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/rwcp_if.sv
// rwcp_char_if, rwcp_wr_if: valid/ready channels for received characters and register writes
// depends on rwcp_pkg

interface rwcp_char_if;
    logic                        valid;
    logic                        ready;
    logic [rwcp_pkg::CHAR_W-1:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface rwcp_wr_if;
    logic                       valid;
    logic                       ready;
    logic [rwcp_pkg::REG_W-1:0] reg_number;
    logic [rwcp_pkg::VAL_W-1:0] reg_value;

    modport source (output valid, output reg_number, output reg_value, input ready);
    modport sink   (input valid, input reg_number, input reg_value, output ready);
endinterface

>>> hw/rtl/register_write_command_parser.sv
// register_write_command_parser: parses "C n = h h CR" character streams into register writes
// depends on rwcp_pkg and rwcp_if
//
// One character beat is accepted per cycle into an input register; from that register it
// walks the six-state parser and, on a carriage return that completes a command, loads the
// result register. The sustained rate is one character per cycle, set by the single parser
// update between the two registers; input stalls only while a completed write waits in the
// full result register and a second command finishes behind it. Upper- or lower-case C and
// hex letters are taken; an unexpected character drops the parser back to idle and is not
// looked at again.

module register_write_command_parser (
    input logic i_clk,
    input logic i_rst_n,
    rwcp_char_if.sink i_in,
    rwcp_wr_if.source o_out
);
    import rwcp_pkg::*;

    logic              r_stage_valid;
    logic [CHAR_W-1:0] r_char;
    t_parse_state      r_state, n_state;
    logic [REG_W-1:0]  r_held_reg, n_held_reg;
    logic [VAL_W-1:0]  r_held_val, n_held_val;
    logic              r_out_valid;
    logic [REG_W-1:0]  r_out_num;
    logic [VAL_W-1:0]  r_out_val;

    logic              emit;
    logic              advance;
    logic              in_fire;
    t_hex              hex;
    logic [CHAR_W-1:0] digit;

    assign hex   = hex_decode(r_char);
    assign digit = r_char - CH_ZERO;

    always_comb begin
        n_state    = PS_IDLE;
        n_held_reg = r_held_reg;
        n_held_val = r_held_val;
        emit       = 1'b0;
        case (r_state)
            PS_IDLE: begin
                if (r_char == CH_C_UPPER || r_char == CH_C_LOWER) begin
                    n_state = PS_GOT_C;
                end
            end
            PS_GOT_C: begin
                if (r_char inside {[CH_ONE:CH_NINE]}) begin
                    n_held_reg = digit[REG_W-1:0];
                    n_state    = PS_GOT_R;
                end
            end
            PS_GOT_R: begin
                if (r_char == CH_EQUAL) begin
                    n_state = PS_GOT_EQ;
                end
            end
            PS_GOT_EQ: begin
                if (hex.ok) begin
                    n_held_val = {hex.nib, {NIB_W{1'b0}}};
                    n_state    = PS_HI;
                end
            end
            PS_HI: begin
                if (hex.ok) begin
                    n_held_val = {r_held_val[VAL_W-1:NIB_W], hex.nib};
                    n_state    = PS_LO;
                end
            end
            PS_LO: begin
                emit = (r_char == CH_CR);
            end
            default: begin
                n_state = PS_IDLE;
            end
        endcase
    end

    // result slot is free, or draining this cycle, or the character makes no result
    assign advance     = r_stage_valid && (!emit || !r_out_valid || o_out.ready);
    assign i_in.ready  = !r_stage_valid || advance;
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.reg_number = r_out_num;
    assign o_out.reg_value  = r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_state       <= PS_IDLE;
            r_held_reg    <= '0;
            r_held_val    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_stage_valid <= 1'b1;
            end else if (advance) begin
                r_stage_valid <= 1'b0;
            end
            if (advance) begin
                r_state    <= n_state;
                r_held_reg <= n_held_reg;
                r_held_val <= n_held_val;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_char <= i_in.rx_char;
        end
        if (advance && emit) begin
            r_out_num <= r_held_reg;
            r_out_val <= r_held_val;
        end
    end

endmodule
